>>> hw/rtl/cbrd_pkg.sv
// Shared types and constants of the cartridge bank register decoder.
`default_nettype none

package cbrd_pkg;

    // Bus event codes carried by the func field.
    localparam logic [2:0] FUNC_REG_READ   = 3'd0;
    localparam logic [2:0] FUNC_REG_WRITE  = 3'd1;
    localparam logic [2:0] FUNC_WINDOW     = 3'd2;
    localparam logic [2:0] FUNC_COLD_START = 3'd3;
    localparam logic [2:0] FUNC_BANK_RESET = 3'd4;

    // Register offsets within the I/O page.
    localparam logic [7:0] REG_OS_BANK    = 8'hE1;
    localparam logic [7:0] REG_CLOCK      = 8'hE2;
    localparam logic [7:0] REG_CART_BANK  = 8'hE4;
    localparam logic [4:0] REG_IDE_HI     = 5'b11110;  // F0..F7
    localparam logic [5:0] REG_CTL_HI     = 6'b111110; // F8..FB
    localparam logic [7:0] REG_IDE_CTL    = 8'hF8;
    localparam logic [7:0] REG_IDE_STATUS = 8'hF9;
    localparam logic [7:0] REG_ID_0       = 8'hFC;
    localparam logic [7:0] REG_ID_1       = 8'hFD;
    localparam logic [7:0] REG_ID_2       = 8'hFE;
    localparam logic [7:0] REG_ID_3       = 8'hFF;

    // Constant bytes returned by reads.
    localparam logic [7:0] CTL_READ_BYTE  = 8'h32;
    localparam logic [7:0] ID0_SWITCH_ON  = 8'h53;
    localparam logic [7:0] ID0_SWITCH_OFF = 8'h20;
    localparam logic [7:0] ID1_BYTE       = 8'h49;
    localparam logic [7:0] ID2_BYTE       = 8'h44;
    localparam logic [7:0] ID3_BYTE       = 8'h45;
    localparam logic [7:0] RTC_DATA_BYTE  = 8'h08;
    localparam logic [7:0] IDE_IDLE_BYTE  = 8'hFF;

    // Bank value of the top register after reset.
    localparam logic [5:0] CART_BANK_INIT = 6'h20;

    // Storage access codes.
    localparam logic [1:0] IDE_NONE  = 2'd0;
    localparam logic [1:0] IDE_READ  = 2'd1;
    localparam logic [1:0] IDE_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_SWITCH  = 1'b0;
    localparam logic CFG_PRESENT = 1'b1;

    // One result item.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_valid;
        logic [18:0] flash_addr;
        logic        left_window_active;
        logic        right_window_active;
        logic        left_subcart_active;
        logic [1:0]  ide_access;
        logic [2:0]  ide_reg;
        logic [7:0]  ide_write_data;
        logic        ide_rst;
        logic        rtc_write;
        logic [2:0]  rtc_pins;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/cartridge_bank_register_decoder_top.sv
// Top level of the cartridge bank register decoder: state, decode and output skid stage.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | i_valid / o_ready      | i_func, i_reg_offset, i_write_data, ...
//  result   | o_valid / i_ready      | o_read_data, o_flash_addr, o_ide_*, ...
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item is decoded in the cycle it is accepted and its result is registered, so one
// item can be taken every cycle while the skid register is empty.
// A skid register behind the result register holds one more result when the
// result side stalls; o_ready drops only while that skid register is full.
// Reset (synchronous, active low) restores the bank and storage state.
// Configuration writes are always accepted and are registered when taken.
`default_nettype none

module cartridge_bank_register_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic        i_cfg_data,
    // Input item channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_func,
    input  wire logic [7:0]  i_reg_offset,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [13:0] i_cart_offset,
    input  wire logic [7:0]  i_ide_read_data,
    input  wire logic        i_rtc_data_out,
    input  wire logic        i_left_window_en,
    input  wire logic        i_right_window_en,
    // Result item channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_read_data,
    output logic             o_read_valid,
    output logic [18:0]      o_flash_addr,
    output logic             o_left_window_active,
    output logic             o_right_window_active,
    output logic             o_left_subcart_active,
    output logic [1:0]       o_ide_access,
    output logic [2:0]       o_ide_reg,
    output logic [7:0]       o_ide_write_data,
    output logic             o_ide_rst,
    output logic             o_rtc_write,
    output logic [2:0]       o_rtc_pins
);

    // Configuration registers.
    logic r_sdx_switch, r_block_present;

    // Bank and storage state.
    logic [7:0] r_sdx_latch, n_sdx_latch;
    logic [7:0] r_top_latch, n_top_latch;
    logic [5:0] r_sdx_bank, n_sdx_bank;
    logic       r_sdx_off, n_sdx_off;
    logic       r_top_enable, n_top_enable;
    logic [5:0] r_cart_bank, n_cart_bank;
    logic       r_top_left_en, n_top_left_en;
    logic       r_top_right_en, n_top_right_en;
    logic [5:0] r_offset_bank, n_offset_bank;
    logic       r_ide_enabled, n_ide_enabled;
    logic       r_ide_removed, n_ide_removed;
    logic       r_ide_rst_req, n_ide_rst_req;

    // Result and skid registers.
    cbrd_pkg::t_result r_out, r_skid, n_result;
    logic              r_out_valid, r_skid_valid;

    logic in_fire, out_fire, cfg_fire;
    logic ide_ok, is_ide_reg, is_ctl_reg, do_bank_update, do_bank_reset;
    logic sdx_read, top_read, top_left_read;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;
    assign o_ready     = ~r_skid_valid;
    assign in_fire     = i_valid & o_ready;
    assign o_valid     = r_out_valid;
    assign out_fire    = r_out_valid & i_ready;

    assign ide_ok     = r_ide_enabled & r_block_present;
    assign is_ide_reg = (i_reg_offset[7:3] == cbrd_pkg::REG_IDE_HI);
    assign is_ctl_reg = (i_reg_offset[7:2] == cbrd_pkg::REG_CTL_HI);

    // Next bank and storage state for the item at the inputs.
    always_comb begin
        n_sdx_latch     = r_sdx_latch;
        n_top_latch     = r_top_latch;
        n_sdx_bank      = r_sdx_bank;
        n_sdx_off       = r_sdx_off;
        n_top_enable    = r_top_enable;
        n_cart_bank     = r_cart_bank;
        n_top_left_en   = r_top_left_en;
        n_top_right_en  = r_top_right_en;
        n_ide_enabled   = r_ide_enabled;
        n_ide_removed   = r_ide_removed;
        n_ide_rst_req   = r_ide_rst_req;
        do_bank_update  = 1'b0;
        do_bank_reset   = (i_func == cbrd_pkg::FUNC_COLD_START) ||
                          (i_func == cbrd_pkg::FUNC_BANK_RESET);

        if (do_bank_reset) begin
            // Both latches decode as if zero had been written.
            n_sdx_latch    = '0;
            n_sdx_off      = 1'b0;
            n_sdx_bank     = '0;
            n_top_enable   = 1'b1;
            n_top_latch    = '0;
            n_top_right_en = 1'b0;
            n_top_left_en  = 1'b1;
            n_cart_bank    = cbrd_pkg::CART_BANK_INIT;
            do_bank_update = 1'b1;
        end else if (i_func == cbrd_pkg::FUNC_REG_WRITE) begin
            if (i_reg_offset == cbrd_pkg::REG_OS_BANK) begin
                n_sdx_latch    = i_write_data;
                n_sdx_off      = i_write_data[7];
                n_sdx_bank     = i_write_data[7] ? 6'd0 : i_write_data[5:0];
                n_top_enable   = ~i_write_data[6];
                do_bank_update = 1'b1;
            end else if (i_reg_offset == cbrd_pkg::REG_CART_BANK) begin
                n_top_latch    = i_write_data;
                n_top_right_en = i_write_data[6];
                n_top_left_en  = ~i_write_data[7];
                // 16K mode forces the low bank bit.
                n_cart_bank    = {~i_write_data[5], i_write_data[4:1],
                                  i_write_data[0] | i_write_data[6]};
                do_bank_update = 1'b1;
            end else if (is_ctl_reg) begin
                if (i_reg_offset == cbrd_pkg::REG_IDE_STATUS && r_block_present) begin
                    n_ide_removed = 1'b0;
                end
                n_ide_enabled = ~i_write_data[7];
                if (i_reg_offset == cbrd_pkg::REG_IDE_CTL) begin
                    n_ide_rst_req = ~i_write_data[0];
                end
            end
        end

        if (i_func == cbrd_pkg::FUNC_COLD_START) begin
            n_ide_rst_req   = 1'b1;
            n_ide_enabled   = 1'b1;
            n_ide_removed   = ~r_block_present;
        end

        // Bank offset follows the selected source and holds when none is.
        n_offset_bank = r_offset_bank;
        if (do_bank_update) begin
            if (r_sdx_switch && !n_sdx_off) begin
                n_offset_bank = n_sdx_bank;
            end else if (n_top_enable || !r_sdx_switch) begin
                n_offset_bank = n_cart_bank;
            end
        end
    end

    // Result fields for the item at the inputs.
    always_comb begin
        n_result = '0;

        unique case (i_func)
            cbrd_pkg::FUNC_REG_READ: begin
                n_result.read_valid = 1'b1;
                if (i_reg_offset == cbrd_pkg::REG_OS_BANK) begin
                    n_result.read_data = r_sdx_latch;
                end else if (i_reg_offset == cbrd_pkg::REG_CLOCK) begin
                    n_result.read_data = i_rtc_data_out ? cbrd_pkg::RTC_DATA_BYTE : 8'd0;
                end else if (i_reg_offset == cbrd_pkg::REG_CART_BANK) begin
                    n_result.read_data = r_top_latch;
                end else if (is_ide_reg) begin
                    if (ide_ok) begin
                        n_result.read_data  = i_ide_read_data;
                        n_result.ide_access = cbrd_pkg::IDE_READ;
                        n_result.ide_reg    = i_reg_offset[2:0];
                    end else begin
                        n_result.read_data = cbrd_pkg::IDE_IDLE_BYTE;
                    end
                end else if (i_reg_offset == cbrd_pkg::REG_IDE_CTL) begin
                    n_result.read_data = cbrd_pkg::CTL_READ_BYTE;
                end else if (i_reg_offset == cbrd_pkg::REG_IDE_STATUS) begin
                    n_result.read_data = {7'd0, r_ide_removed};
                end else if (i_reg_offset == cbrd_pkg::REG_ID_0) begin
                    n_result.read_data = r_sdx_switch ? cbrd_pkg::ID0_SWITCH_ON
                                                      : cbrd_pkg::ID0_SWITCH_OFF;
                end else if (i_reg_offset == cbrd_pkg::REG_ID_1) begin
                    n_result.read_data = cbrd_pkg::ID1_BYTE;
                end else if (i_reg_offset == cbrd_pkg::REG_ID_2) begin
                    n_result.read_data = cbrd_pkg::ID2_BYTE;
                end else if (i_reg_offset == cbrd_pkg::REG_ID_3) begin
                    n_result.read_data = cbrd_pkg::ID3_BYTE;
                end else begin
                    n_result.read_valid = 1'b0;
                end
            end
            cbrd_pkg::FUNC_REG_WRITE: begin
                if (i_reg_offset == cbrd_pkg::REG_CLOCK) begin
                    n_result.rtc_write = 1'b1;
                    n_result.rtc_pins  = {i_write_data[2], ~i_write_data[1], i_write_data[0]};
                end else if (is_ide_reg && ide_ok) begin
                    n_result.ide_access     = cbrd_pkg::IDE_WRITE;
                    n_result.ide_reg        = i_reg_offset[2:0];
                    n_result.ide_write_data = i_write_data;
                end
            end
            cbrd_pkg::FUNC_WINDOW: begin
                // The upper 8K half uses the full bank; the lower half its even partner.
                n_result.flash_addr = {r_offset_bank[5:1],
                                       i_cart_offset[13] & r_offset_bank[0],
                                       i_cart_offset[12:0]};
            end
            default: begin
            end
        endcase

        // Window outputs come from the state after the item.
        sdx_read      = r_sdx_switch & ~n_sdx_off;
        top_read      = n_top_enable | ~r_sdx_switch;
        top_left_read = top_read & n_top_left_en;
        n_result.left_window_active  = i_left_window_en & (sdx_read | top_left_read);
        n_result.right_window_active = i_right_window_en & top_read & ~sdx_read &
                                       n_top_right_en;
        n_result.left_subcart_active = sdx_read | top_left_read;
        n_result.ide_rst             = n_ide_rst_req | ~r_block_present;
    end

    // Bank and storage state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdx_latch     <= '0;
            r_top_latch     <= '0;
            r_sdx_bank      <= '0;
            r_sdx_off       <= 1'b0;
            r_top_enable    <= 1'b1;
            r_cart_bank     <= cbrd_pkg::CART_BANK_INIT;
            r_top_left_en   <= 1'b1;
            r_top_right_en  <= 1'b0;
            r_offset_bank   <= '0;
            r_ide_enabled   <= 1'b1;
            r_ide_removed   <= 1'b1;
            r_ide_rst_req   <= 1'b1;
        end else if (in_fire) begin
            r_sdx_latch     <= n_sdx_latch;
            r_top_latch     <= n_top_latch;
            r_sdx_bank      <= n_sdx_bank;
            r_sdx_off       <= n_sdx_off;
            r_top_enable    <= n_top_enable;
            r_cart_bank     <= n_cart_bank;
            r_top_left_en   <= n_top_left_en;
            r_top_right_en  <= n_top_right_en;
            r_offset_bank   <= n_offset_bank;
            r_ide_enabled   <= n_ide_enabled;
            r_ide_removed   <= n_ide_removed;
            r_ide_rst_req   <= n_ide_rst_req;
        end else if (cfg_fire && i_cfg_index == cbrd_pkg::CFG_SWITCH) begin
            // A new switch setting re-selects the bank source.
            if (i_cfg_data && !r_sdx_off) begin
                r_offset_bank <= r_sdx_bank;
            end else if (r_top_enable || !i_cfg_data) begin
                r_offset_bank <= r_cart_bank;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdx_switch    <= 1'b1;
            r_block_present <= 1'b0;
        end else if (cfg_fire) begin
            if (i_cfg_index == cbrd_pkg::CFG_SWITCH) begin
                r_sdx_switch <= i_cfg_data;
            end else begin
                r_block_present <= i_cfg_data;
            end
        end
    end

    // Result register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_read_data           = r_out.read_data;
    assign o_read_valid          = r_out.read_valid;
    assign o_flash_addr          = r_out.flash_addr;
    assign o_left_window_active  = r_out.left_window_active;
    assign o_right_window_active = r_out.right_window_active;
    assign o_left_subcart_active = r_out.left_subcart_active;
    assign o_ide_access          = r_out.ide_access;
    assign o_ide_reg             = r_out.ide_reg;
    assign o_ide_write_data      = r_out.ide_write_data;
    assign o_ide_rst             = r_out.ide_rst;
    assign o_rtc_write           = r_out.rtc_write;
    assign o_rtc_pins            = r_out.rtc_pins;

    // The skid register is only filled behind a full result register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while result register empty");

    // A full skid register stays full until the result side takes an item.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_ready |=> r_skid_valid)
        else $error("skid register lost an item");

    // A storage write never drives the read bus or the clock pins.
    a_ide_write_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.ide_access == cbrd_pkg::IDE_WRITE |->
            !r_out.read_valid && !r_out.rtc_write)
        else $error("storage write mixed with read or clock write");

    // Storage access codes stay within their defined set.
    a_ide_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.ide_access == cbrd_pkg::IDE_NONE ||
                         r_out.ide_access == cbrd_pkg::IDE_READ ||
                         r_out.ide_access == cbrd_pkg::IDE_WRITE))
        else $error("undefined storage access code");

endmodule

`default_nettype wire

>>> verif/cbrd_result_checker.sv
// Result checker for the cartridge bank register decoder: predicts each result item and compares it.
`timescale 1ns / 100ps

module cbrd_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration channel, watched only.
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    // Input item channel, watched only.
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_reg_offset,
    input  logic [7:0]  i_write_data,
    input  logic [13:0] i_cart_offset,
    input  logic [7:0]  i_ide_read_data,
    input  logic        i_rtc_data_out,
    input  logic        i_left_window_en,
    input  logic        i_right_window_en,
    // Result item channel, watched only.
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_read_data,
    input  logic        o_read_valid,
    input  logic [18:0] o_flash_addr,
    input  logic        o_left_window_active,
    input  logic        o_right_window_active,
    input  logic        o_left_subcart_active,
    input  logic [1:0]  o_ide_access,
    input  logic [2:0]  o_ide_reg,
    input  logic [7:0]  o_ide_write_data,
    input  logic        o_ide_rst,
    input  logic        o_rtc_write,
    input  logic [2:0]  o_rtc_pins,
    // Status handed to the testbench top.
    output int          o_mismatch_count,
    output int          o_pending_count,
    output int          o_result_count
);

    localparam int unsigned REPORT_LIMIT = 10;
    localparam logic [18:0] WINDOW_HALF  = 19'h02000;

    // Predicted configuration.
    logic       mode_switch;
    logic       card_present;

    // Predicted banking state.
    logic [7:0] os_latch;
    logic [7:0] top_latch;
    logic [5:0] os_bank;
    logic       os_off;
    logic       top_en;
    logic [5:0] cart_bank;
    logic       top_left;
    logic       top_right;
    logic [5:0] flash_bank;

    // Predicted storage flags.
    logic       ide_en;
    logic       ide_gone;
    logic       ide_rst_req;

    // Results predicted but not yet seen, oldest first.
    cbrd_pkg::t_result awaited_results[$];
    cbrd_pkg::t_result observed;

    assign observed = {o_read_data, o_read_valid, o_flash_addr, o_left_window_active,
                       o_right_window_active, o_left_subcart_active, o_ide_access, o_ide_reg,
                       o_ide_write_data, o_ide_rst, o_rtc_write, o_rtc_pins};

    // Decode a byte written to the operating system bank register.
    function automatic void load_os_bank(input logic [7:0] value);
        os_latch = value;
        os_off   = value[7];
        os_bank  = value[7] ? 6'd0 : value[5:0];
        top_en   = ~value[6];
    endfunction

    // Decode a byte written to the top cartridge bank register; 16K mode forces an odd bank.
    function automatic void load_cart_bank(input logic [7:0] value);
        top_latch = value;
        top_right = value[6];
        top_left  = ~value[7];
        cart_bank = value[5:0] ^ cbrd_pkg::CART_BANK_INIT;
        if (top_right) begin
            cart_bank[0] = 1'b1;
        end
    endfunction

    // The flash offset follows the selected source and holds when neither is selected.
    function automatic void refresh_offset();
        if (mode_switch && !os_off) begin
            flash_bank = os_bank;
        end else if (top_en || !mode_switch) begin
            flash_bank = cart_bank;
        end
    endfunction

    function automatic void restore_banks();
        load_os_bank(8'h00);
        load_cart_bank(8'h00);
        refresh_offset();
    endfunction

    function automatic void reset_model();
        mode_switch  = 1'b1;
        card_present = 1'b0;
        restore_banks();
        flash_bank   = 6'd0;
        ide_en       = 1'b1;
        ide_gone     = 1'b1;
        ide_rst_req  = 1'b1;
    endfunction

    function automatic void write_setting(input logic index, input logic value);
        if (index == cbrd_pkg::CFG_SWITCH) begin
            mode_switch = value;
            refresh_offset();
        end else begin
            card_present = value;
        end
    endfunction

    // Apply one bus event to the predicted state and work out its result item.
    function automatic cbrd_pkg::t_result bus_event_result(
        input logic [2:0]  func,
        input logic [7:0]  offset,
        input logic [7:0]  data,
        input logic [13:0] cart_offset,
        input logic [7:0]  ide_data,
        input logic        rtc_in,
        input logic        left_en,
        input logic        right_en
    );
        cbrd_pkg::t_result res;
        logic        ide_ok;
        logic [18:0] base;
        logic        os_sel;
        logic        top_sel;
        logic        top_left_sel;
        res    = '0;
        ide_ok = ide_en && card_present;
        case (func)
            cbrd_pkg::FUNC_REG_READ: begin
                res.read_valid = 1'b1;
                if (offset == cbrd_pkg::REG_OS_BANK) begin
                    res.read_data = os_latch;
                end else if (offset == cbrd_pkg::REG_CLOCK) begin
                    res.read_data = rtc_in ? cbrd_pkg::RTC_DATA_BYTE : 8'h00;
                end else if (offset == cbrd_pkg::REG_CART_BANK) begin
                    res.read_data = top_latch;
                end else if (offset[7:3] == cbrd_pkg::REG_IDE_HI) begin
                    if (ide_ok) begin
                        res.read_data  = ide_data;
                        res.ide_access = cbrd_pkg::IDE_READ;
                        res.ide_reg    = offset[2:0];
                    end else begin
                        res.read_data = cbrd_pkg::IDE_IDLE_BYTE;
                    end
                end else if (offset == cbrd_pkg::REG_IDE_CTL) begin
                    res.read_data = cbrd_pkg::CTL_READ_BYTE;
                end else if (offset == cbrd_pkg::REG_IDE_STATUS) begin
                    res.read_data = {7'd0, ide_gone};
                end else if (offset == cbrd_pkg::REG_ID_0) begin
                    res.read_data = mode_switch ? cbrd_pkg::ID0_SWITCH_ON
                                                : cbrd_pkg::ID0_SWITCH_OFF;
                end else if (offset == cbrd_pkg::REG_ID_1) begin
                    res.read_data = cbrd_pkg::ID1_BYTE;
                end else if (offset == cbrd_pkg::REG_ID_2) begin
                    res.read_data = cbrd_pkg::ID2_BYTE;
                end else if (offset == cbrd_pkg::REG_ID_3) begin
                    res.read_data = cbrd_pkg::ID3_BYTE;
                end else begin
                    res.read_valid = 1'b0;
                end
            end
            cbrd_pkg::FUNC_REG_WRITE: begin
                if (offset == cbrd_pkg::REG_OS_BANK) begin
                    load_os_bank(data);
                    refresh_offset();
                end else if (offset == cbrd_pkg::REG_CLOCK) begin
                    // The chip select pin is driven from the inverted byte bit.
                    res.rtc_write = 1'b1;
                    res.rtc_pins  = {data[2], ~data[1], data[0]};
                end else if (offset == cbrd_pkg::REG_CART_BANK) begin
                    load_cart_bank(data);
                    refresh_offset();
                end else if (offset[7:3] == cbrd_pkg::REG_IDE_HI) begin
                    if (ide_ok) begin
                        res.ide_access     = cbrd_pkg::IDE_WRITE;
                        res.ide_reg        = offset[2:0];
                        res.ide_write_data = data;
                    end
                end else if (offset[7:2] == cbrd_pkg::REG_CTL_HI) begin
                    // Clearing the removed flag only works with a card attached.
                    if (offset == cbrd_pkg::REG_IDE_STATUS && card_present) begin
                        ide_gone = 1'b0;
                    end
                    ide_en = ~data[7];
                    if (offset == cbrd_pkg::REG_IDE_CTL) begin
                        ide_rst_req = ~data[0];
                    end
                end
            end
            cbrd_pkg::FUNC_WINDOW: begin
                base = {flash_bank, 13'd0};
                if (cart_offset[13]) begin
                    res.flash_addr = base + 19'(cart_offset[12:0]);
                end else begin
                    res.flash_addr = (base & ~WINDOW_HALF) + 19'(cart_offset);
                end
            end
            cbrd_pkg::FUNC_COLD_START: begin
                restore_banks();
                ide_rst_req = 1'b1;
                ide_en      = 1'b1;
                ide_gone    = ~card_present;
            end
            cbrd_pkg::FUNC_BANK_RESET: begin
                restore_banks();
            end
            default: begin
            end
        endcase

        // Window outputs always reflect the state after the event.
        os_sel                  = mode_switch && !os_off;
        top_sel                 = top_en || !mode_switch;
        top_left_sel            = top_sel && top_left;
        res.left_window_active  = left_en && (os_sel || top_left_sel);
        res.right_window_active = right_en && top_sel && !os_sel && top_right;
        res.left_subcart_active = os_sel || top_left_sel;
        res.ide_rst             = ide_rst_req || !card_present;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [18:0] want,
                               input logic [18:0] got);
        if (got !== want) begin
            o_mismatch_count++;
            if (o_mismatch_count <= REPORT_LIMIT) begin
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         o_result_count, name, want, got);
            end
        end
    endtask

    task automatic compare_result(input cbrd_pkg::t_result want,
                                  input cbrd_pkg::t_result got);
        check_field("read_data", 19'(want.read_data), 19'(got.read_data));
        check_field("read_valid", 19'(want.read_valid), 19'(got.read_valid));
        check_field("flash_addr", want.flash_addr, got.flash_addr);
        check_field("left_window_active", 19'(want.left_window_active),
                    19'(got.left_window_active));
        check_field("right_window_active", 19'(want.right_window_active),
                    19'(got.right_window_active));
        check_field("left_subcart_active", 19'(want.left_subcart_active),
                    19'(got.left_subcart_active));
        check_field("ide_access", 19'(want.ide_access), 19'(got.ide_access));
        check_field("ide_reg", 19'(want.ide_reg), 19'(got.ide_reg));
        check_field("ide_write_data", 19'(want.ide_write_data), 19'(got.ide_write_data));
        check_field("ide_rst", 19'(want.ide_rst), 19'(got.ide_rst));
        check_field("rtc_write", 19'(want.rtc_write), 19'(got.rtc_write));
        check_field("rtc_pins", 19'(want.rtc_pins), 19'(got.rtc_pins));
    endtask

    // Everything is settled at the falling edge; a handshake seen here completes at the
    // next rising edge. Results are taken before new items since each result is registered.
    always @(negedge i_clk) begin : watch_channels
        if (!i_rst_n) begin
            reset_model();
            awaited_results.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (awaited_results.size() == 0) begin
                    o_mismatch_count++;
                    if (o_mismatch_count <= REPORT_LIMIT) begin
                        $display("result %0d arrived with no item outstanding", o_result_count);
                    end
                end else begin
                    compare_result(awaited_results.pop_front(), observed);
                end
                o_result_count++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_setting(i_cfg_index, i_cfg_data);
            end
            if (i_valid && o_ready) begin
                awaited_results.push_back(bus_event_result(i_func, i_reg_offset, i_write_data,
                    i_cart_offset, i_ide_read_data, i_rtc_data_out, i_left_window_en,
                    i_right_window_en));
            end
        end
        o_pending_count = awaited_results.size();
    end

endmodule

>>> verif/tb_cartridge_bank_register_decoder_top.sv
// Testbench top for the cartridge bank register decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_cartridge_bank_register_decoder_top;

    localparam int unsigned RESET_CYCLES    = 8;
    localparam int unsigned IDLE_PCT        = 13;
    localparam int unsigned HOLD_CYCLES     = 80;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned PHASES          = 6;
    localparam int unsigned ITEMS_PER_PHASE = 325;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam logic [7:0]  UNMAPPED_REG    = 8'h00;
    localparam logic [2:0]  UNUSED_FUNC     = 3'd7;

    // Mode switch and card presence for each random phase, phase 0 in bit 0.
    localparam logic [5:0]  SWITCH_PLAN     = 6'b011001;
    localparam logic [5:0]  PRESENT_PLAN    = 6'b010011;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  reg_offset;
        logic [7:0]  write_data;
        logic [13:0] cart_offset;
        logic [7:0]  ide_read_data;
        logic        rtc_data_out;
        logic        left_window_en;
        logic        right_window_en;
    } t_bus_event;

    logic        i_clk;
    logic        i_rst_n           = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index       = 1'b0;
    logic        i_cfg_data        = 1'b0;
    logic        i_valid           = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func            = '0;
    logic [7:0]  i_reg_offset      = '0;
    logic [7:0]  i_write_data      = '0;
    logic [13:0] i_cart_offset     = '0;
    logic [7:0]  i_ide_read_data   = '0;
    logic        i_rtc_data_out    = 1'b0;
    logic        i_left_window_en  = 1'b0;
    logic        i_right_window_en = 1'b0;
    logic        o_valid;
    logic        i_ready           = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_read_valid;
    logic [18:0] o_flash_addr;
    logic        o_left_window_active;
    logic        o_right_window_active;
    logic        o_left_subcart_active;
    logic [1:0]  o_ide_access;
    logic [2:0]  o_ide_reg;
    logic [7:0]  o_ide_write_data;
    logic        o_ide_rst;
    logic        o_rtc_write;
    logic [2:0]  o_rtc_pins;

    int          o_mismatch_count;
    int          o_pending_count;
    int          o_result_count;

    // Traffic shaping shared by the sender and the result side.
    logic        steady            = 1'b0;
    logic        hold_request      = 1'b0;
    logic        hold_done         = 1'b0;
    int unsigned held_cycles       = 0;
    int unsigned events_sent       = 0;
    int unsigned settings_used     = 0;

    cartridge_bank_register_decoder_top i_dut (.*);

    cbrd_result_checker i_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, none in the steady stretch, one long hold on request.
    always @(posedge i_clk) begin
        if (hold_request && !hold_done) begin
            if (held_cycles == HOLD_CYCLES) begin
                hold_done    <= 1'b1;
                held_cycles  <= 0;
                i_ready      <= 1'b1;
            end else begin
                held_cycles  <= held_cycles + 1;
                i_ready      <= 1'b0;
            end
        end else begin
            i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results still awaited", cycles, o_pending_count);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_bus_event make_event(input logic [2:0] func, input logic [7:0] offset,
                                              input logic [7:0] data, input logic [13:0] cart);
        t_bus_event ev;
        ev.func            = func;
        ev.reg_offset      = offset;
        ev.write_data      = data;
        ev.cart_offset     = cart;
        ev.ide_read_data   = ~data;
        ev.rtc_data_out    = data[0];
        ev.left_window_en  = 1'b1;
        ev.right_window_en = 1'b1;
        return ev;
    endfunction

    // Random bus event, weighted toward the decoded registers and bank traffic.
    function automatic t_bus_event random_event();
        t_bus_event  ev;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            ev.func = cbrd_pkg::FUNC_REG_READ;
        end else if (pick < 65) begin
            ev.func = cbrd_pkg::FUNC_REG_WRITE;
        end else if (pick < 90) begin
            ev.func = cbrd_pkg::FUNC_WINDOW;
        end else if (pick < 93) begin
            ev.func = cbrd_pkg::FUNC_COLD_START;
        end else if (pick < 97) begin
            ev.func = cbrd_pkg::FUNC_BANK_RESET;
        end else begin
            ev.func = 3'($urandom_range(7, 5));
        end
        pick = $urandom_range(99);
        if (pick < 25) begin
            ev.reg_offset = 8'($urandom_range(255));
        end else if (pick < 45) begin
            ev.reg_offset = cbrd_pkg::REG_OS_BANK;
        end else if (pick < 55) begin
            ev.reg_offset = cbrd_pkg::REG_CLOCK;
        end else if (pick < 70) begin
            ev.reg_offset = cbrd_pkg::REG_CART_BANK;
        end else begin
            ev.reg_offset = {4'hF, 4'($urandom_range(15))};
        end
        ev.write_data = 8'($urandom);
        // Keep the storage port enabled most of the time so its accesses go through.
        if (ev.func == cbrd_pkg::FUNC_REG_WRITE && ev.reg_offset[7:2] == cbrd_pkg::REG_CTL_HI)
        begin
            ev.write_data[7] = ($urandom_range(3) == 0);
        end
        ev.cart_offset     = 14'($urandom);
        ev.ide_read_data   = 8'($urandom);
        ev.rtc_data_out    = 1'($urandom);
        ev.left_window_en  = 1'($urandom);
        ev.right_window_en = 1'($urandom);
        return ev;
    endfunction

    // Offer one item after an optional random gap and wait until it is taken.
    task automatic send_event(input t_bus_event ev);
        logic took;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_func            <= ev.func;
        i_reg_offset      <= ev.reg_offset;
        i_write_data      <= ev.write_data;
        i_cart_offset     <= ev.cart_offset;
        i_ide_read_data   <= ev.ide_read_data;
        i_rtc_data_out    <= ev.rtc_data_out;
        i_left_window_en  <= ev.left_window_en;
        i_right_window_en <= ev.right_window_en;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        events_sent++;
    endtask

    // Stop sending, wait for every awaited result, then let the output stage settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (o_pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic await_cfg();
        logic took;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // Write both configuration registers back to back.
    task automatic apply_setting(input logic sw, input logic present);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= cbrd_pkg::CFG_SWITCH;
        i_cfg_data  <= sw;
        await_cfg();
        i_cfg_index <= cbrd_pkg::CFG_PRESENT;
        i_cfg_data  <= present;
        await_cfg();
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset configuration: every read, the bank decode corners.
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_OS_BANK, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_CLOCK, 8'h01, 14'h3FFF));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_CLOCK, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_CART_BANK, 8'hFF,
                              14'h3FFF));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, {cbrd_pkg::REG_IDE_HI, 3'd0}, 8'h00,
                              14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_IDE_CTL, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_IDE_STATUS, 8'h00,
                              14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_ID_0, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_ID_1, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_ID_2, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, cbrd_pkg::REG_ID_3, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_READ, UNMAPPED_REG, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_WRITE, cbrd_pkg::REG_CLOCK, 8'hFF, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_WRITE, cbrd_pkg::REG_CLOCK, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_WINDOW, UNMAPPED_REG, 8'h00, 14'h3FFF));
        // Operating system bank switched off: the top bank takes over.
        send_event(make_event(cbrd_pkg::FUNC_REG_WRITE, cbrd_pkg::REG_OS_BANK, 8'h80, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_WINDOW, UNMAPPED_REG, 8'h00, 14'h1FFF));
        // Top 16K mode forces an odd bank.
        send_event(make_event(cbrd_pkg::FUNC_REG_WRITE, cbrd_pkg::REG_CART_BANK, 8'h7F,
                              14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_WINDOW, UNMAPPED_REG, 8'h00, 14'h2000));
        // Neither source selected: the bank offset holds.
        send_event(make_event(cbrd_pkg::FUNC_REG_WRITE, cbrd_pkg::REG_OS_BANK, 8'hC0, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_WINDOW, UNMAPPED_REG, 8'h00, 14'h0000));
        // Storage control with no card: the removed flag stays and accesses are dropped.
        send_event(make_event(cbrd_pkg::FUNC_REG_WRITE, cbrd_pkg::REG_IDE_STATUS, 8'h00,
                              14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_WRITE, cbrd_pkg::REG_IDE_CTL, 8'h01,
                              14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_REG_WRITE, {cbrd_pkg::REG_IDE_HI, 3'd7}, 8'h5A,
                              14'h0000));
        send_event(make_event(UNUSED_FUNC, UNMAPPED_REG, 8'hFF, 14'h3FFF));
        send_event(make_event(cbrd_pkg::FUNC_COLD_START, UNMAPPED_REG, 8'h00, 14'h0000));
        send_event(make_event(cbrd_pkg::FUNC_BANK_RESET, UNMAPPED_REG, 8'h00, 14'h0000));

        // Random phases, each under its own mode and card setting.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            apply_setting(SWITCH_PLAN[phase], PRESENT_PLAN[phase]);
            steady <= (phase == 1);
            if (phase == 2) begin
                hold_request <= 1'b1;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 3 && n == ITEMS_PER_PHASE / 2) begin
                    wait_idle();
                end
                send_event(random_event());
            end
        end
        wait_idle();

        $display("Sent %0d bus events under %0d mode and card settings, %0d results compared.",
                 events_sent, settings_used, o_result_count);
        $display("Included a stall-free phase, a %0d-cycle result hold and mid-run drains.",
                 HOLD_CYCLES);
        if (o_mismatch_count == 0 && o_pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
